>>> rtl/stramp_pkg.sv
// Package for the stepper trapezoid ramp unit: widths, codes, state encoding
// and the saturating step counter helper. No dependencies.
`timescale 1ns / 1ps

package stramp_pkg;

    localparam int COUNT_BITS    = 24;
    localparam int COMPARE_BITS  = 16;
    localparam int INTERVAL_BITS = 32;
    localparam int TARGET_BITS   = 16;
    localparam int CMD_BITS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Dividend is 2*interval + remainder, divisor is 4*count +/- 1.
    localparam int NUM_W  = INTERVAL_BITS + 2;
    localparam int DIV_W  = COUNT_BITS + 2;
    localparam int DCNT_W = $clog2(NUM_W);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TOGGLE = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_STATUS = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_INTERVAL  = 3'd0,
        CFG_TARGET_INTERVAL = 3'd1,
        CFG_ACCEL_STEPS     = 3'd2,
        CFG_DECEL_START     = 3'd3,
        CFG_DECEL_STEPS     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_RUN   = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_FIN  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

>>> rtl/stepper_trapezoid_ramp_unit.sv
// Stepper trapezoid ramp unit: toggle event handling, profile phases and a
// bit-serial restoring divider for the interval recurrence. Uses stramp_pkg.
`timescale 1ns / 1ps

//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------------
//  request | command, timer_count                      | in_valid / in_stall
//  result  | compare_value, compare_valid, phase_now,  | out_valid / out_stall
//          | steps_done, reached_flag, halt_timer      |
//  config  | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
//  A request that needs no division goes from acceptance through ST_DONE into
//  the result register; a step that runs the interval recurrence (accelerate,
//  or decelerate with countdown left) passes ST_DIV, where the divider shifts
//  one quotient bit per cycle, and ST_FIN first. A decelerate step that
//  spends the countdown needs no division. One request is in work at
//  a time; the result register lets the next request enter while a result
//  still waits on out_stall. Reset is asynchronous, active low, and clears all
//  profile state and loads the register defaults.

module stepper_trapezoid_ramp_unit
    import stramp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_BITS-1:0]      command,
    input  logic [COMPARE_BITS-1:0]  timer_count,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [COMPARE_BITS-1:0]  compare_value,
    output logic                     compare_valid,
    output logic [1:0]               phase_now,
    output logic [COUNT_BITS-1:0]    steps_done,
    output logic                     reached_flag,
    output logic                     halt_timer,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Configuration registers
    logic [INTERVAL_BITS-1:0] start_interval_reg;
    logic [TARGET_BITS-1:0]   target_interval_reg;
    logic [COUNT_BITS-1:0]    accel_steps_reg;
    logic [COUNT_BITS-1:0]    decel_start_reg;
    logic [COUNT_BITS-1:0]    decel_steps_reg;

    // Profile state
    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    logic                     toggle_reg, toggle_next;
    logic [INTERVAL_BITS-1:0] interval_reg, interval_next;
    logic [DIV_W-1:0]         remainder_reg, remainder_next;
    logic [COUNT_BITS-1:0]    ramp_reg, ramp_next;
    logic [COUNT_BITS-1:0]    steps_reg, steps_next;
    logic [COUNT_BITS-1:0]    decel_left_reg, decel_left_next;
    logic                     done_reg, done_next;

    // Pending result of the request in work
    logic [COMPARE_BITS-1:0]  timer_reg, timer_next;
    logic                     cvalid_pend_reg, cvalid_pend_next;
    logic                     halt_pend_reg, halt_pend_next;
    logic                     status_reg, status_next;
    logic                     reached_pend_reg, reached_pend_next;

    // Divider
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [DIV_W-1:0]         prem_reg, prem_next;
    logic [DIV_W-1:0]         divisor_reg, divisor_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    logic [COMPARE_BITS-1:0]  cmp_out_reg, cmp_out_next;
    logic                     cvalid_out_reg, cvalid_out_next;
    logic [1:0]               phase_out_reg, phase_out_next;
    logic [COUNT_BITS-1:0]    steps_out_reg, steps_out_next;
    logic                     reached_out_reg, reached_out_next;
    logic                     halt_out_reg, halt_out_next;

    // Datapath helpers
    logic                     accept;
    logic [COUNT_BITS-1:0]    step_inc;
    logic [COUNT_BITS-1:0]    ramp_inc;
    logic [COUNT_BITS-1:0]    dl_dec;
    logic [NUM_W-1:0]         dividend;
    logic [DIV_W:0]           shifted;
    logic [DIV_W+1:0]         trial;
    logic                     trial_ge;
    logic                     q_ge_int;
    logic [INTERVAL_BITS-1:0] accel_int;
    logic [NUM_W:0]           decel_sum;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;

    assign step_inc = sat_inc(steps_reg);
    assign ramp_inc = sat_inc(ramp_reg);
    assign dl_dec   = (decel_left_reg != '0) ? decel_left_reg - COUNT_BITS'(1)
                                             : decel_left_reg;
    assign dividend = {1'b0, interval_reg, 1'b0} + NUM_W'(remainder_reg);

    // One restoring division step: shift in the next dividend bit, try subtract.
    assign shifted  = {prem_reg, quo_reg[NUM_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, divisor_reg};
    assign trial_ge = !trial[DIV_W+1];

    assign q_ge_int  = (quo_reg >= NUM_W'(interval_reg));
    assign accel_int = q_ge_int ? '0 : interval_reg - quo_reg[INTERVAL_BITS-1:0];
    assign decel_sum = {1'b0, quo_reg} + (NUM_W+1)'(interval_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_interval_reg  <= INTERVAL_BITS'(1);
            target_interval_reg <= TARGET_BITS'(1);
            accel_steps_reg     <= '0;
            decel_start_reg     <= '0;
            decel_steps_reg     <= COUNT_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_INTERVAL:  start_interval_reg  <= cfg_data[INTERVAL_BITS-1:0];
                CFG_TARGET_INTERVAL: target_interval_reg <= cfg_data[TARGET_BITS-1:0];
                CFG_ACCEL_STEPS:     accel_steps_reg     <= cfg_data[COUNT_BITS-1:0];
                CFG_DECEL_START:     decel_start_reg     <= cfg_data[COUNT_BITS-1:0];
                CFG_DECEL_STEPS:     decel_steps_reg     <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_STOP;
            toggle_reg       <= 1'b0;
            interval_reg     <= '0;
            remainder_reg    <= '0;
            ramp_reg         <= '0;
            steps_reg        <= '0;
            decel_left_reg   <= '0;
            done_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            dcnt_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            toggle_reg       <= toggle_next;
            interval_reg     <= interval_next;
            remainder_reg    <= remainder_next;
            ramp_reg         <= ramp_next;
            steps_reg        <= steps_next;
            decel_left_reg   <= decel_left_next;
            done_reg         <= done_next;
            out_valid_reg    <= out_valid_next;
            dcnt_reg         <= dcnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        timer_reg        <= timer_next;
        cvalid_pend_reg  <= cvalid_pend_next;
        halt_pend_reg    <= halt_pend_next;
        status_reg       <= status_next;
        reached_pend_reg <= reached_pend_next;
        quo_reg          <= quo_next;
        prem_reg         <= prem_next;
        divisor_reg      <= divisor_next;
        cmp_out_reg      <= cmp_out_next;
        cvalid_out_reg   <= cvalid_out_next;
        phase_out_reg    <= phase_out_next;
        steps_out_reg    <= steps_out_next;
        reached_out_reg  <= reached_out_next;
        halt_out_reg     <= halt_out_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        toggle_next       = toggle_reg;
        interval_next     = interval_reg;
        remainder_next    = remainder_reg;
        ramp_next         = ramp_reg;
        steps_next        = steps_reg;
        decel_left_next   = decel_left_reg;
        done_next         = done_reg;
        timer_next        = timer_reg;
        cvalid_pend_next  = cvalid_pend_reg;
        halt_pend_next    = halt_pend_reg;
        status_next       = status_reg;
        reached_pend_next = reached_pend_reg;
        quo_next          = quo_reg;
        prem_next         = prem_reg;
        divisor_next      = divisor_reg;
        dcnt_next         = dcnt_reg;
        out_valid_next    = out_valid_reg && out_stall;
        cmp_out_next      = cmp_out_reg;
        cvalid_out_next   = cvalid_out_reg;
        phase_out_next    = phase_out_reg;
        steps_out_next    = steps_out_reg;
        reached_out_next  = reached_out_reg;
        halt_out_next     = halt_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Capture the request; most commands finish right here.
                    timer_next        = timer_count;
                    cvalid_pend_next  = 1'b0;
                    halt_pend_next    = 1'b0;
                    status_next       = (command == CMD_STATUS);
                    reached_pend_next = done_reg;
                    state_next        = ST_DONE;
                    quo_next          = dividend;
                    prem_next         = '0;
                    dcnt_next         = DCNT_W'(NUM_W - 1);
                    case (command)
                        CMD_TOGGLE:
                        begin
                            toggle_next      = !toggle_reg;
                            cvalid_pend_next = 1'b1;
                            // Second toggle of a pair is one motor step.
                            if (toggle_reg)
                            begin
                                case (phase_reg)
                                    PH_STOP:
                                    begin
                                        steps_next     = '0;
                                        remainder_next = '0;
                                        halt_pend_next = 1'b1;
                                    end
                                    PH_ACCEL:
                                    begin
                                        steps_next   = step_inc;
                                        ramp_next    = ramp_inc;
                                        divisor_next = {ramp_inc, 2'b01};
                                        state_next   = ST_DIV;
                                    end
                                    PH_RUN:
                                    begin
                                        steps_next = step_inc;
                                        if (step_inc >= decel_start_reg)
                                        begin
                                            phase_next = PH_DECEL;
                                        end
                                    end
                                    default:
                                    begin
                                        steps_next      = step_inc;
                                        decel_left_next = dl_dec;
                                        if (dl_dec <= COUNT_BITS'(1))
                                        begin
                                            // Countdown spent: stop, keep the interval.
                                            phase_next = PH_STOP;
                                            done_next  = 1'b1;
                                        end
                                        else
                                        begin
                                            divisor_next = {dl_dec - COUNT_BITS'(1), 2'b11};
                                            state_next   = ST_DIV;
                                        end
                                    end
                                endcase
                            end
                        end
                        CMD_START:
                        begin
                            // Ignored while the motor runs.
                            if (phase_reg == PH_STOP)
                            begin
                                interval_next    = start_interval_reg;
                                ramp_next        = '0;
                                steps_next       = '0;
                                remainder_next   = '0;
                                decel_left_next  = decel_steps_reg;
                                done_next        = 1'b0;
                                phase_next       = PH_ACCEL;
                                cvalid_pend_next = 1'b1;
                            end
                        end
                        CMD_STOP:
                        begin
                            phase_next     = PH_STOP;
                            halt_pend_next = 1'b1;
                        end
                        CMD_STATUS:
                        begin
                            done_next = 1'b0;
                        end
                        CMD_CLEAR:
                        begin
                            steps_next = '0;
                            ramp_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                // Advance one quotient bit per cycle.
                quo_next  = {quo_reg[NUM_W-2:0], trial_ge};
                prem_next = trial_ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next     = ST_DONE;
                remainder_next = prem_reg;
                if (phase_reg == PH_ACCEL)
                begin
                    interval_next = accel_int;
                    if (steps_reg >= decel_start_reg)
                    begin
                        phase_next = PH_DECEL;
                    end
                    else if ((accel_int <= INTERVAL_BITS'(target_interval_reg))
                             || (steps_reg >= accel_steps_reg))
                    begin
                        // Cruise reached: clamp to the target, drop the carry.
                        if (accel_int < INTERVAL_BITS'(target_interval_reg))
                        begin
                            interval_next = INTERVAL_BITS'(target_interval_reg);
                        end
                        remainder_next = '0;
                        phase_next     = PH_RUN;
                    end
                end
                else
                begin
                    // Lengthen, saturating at all ones.
                    if (decel_sum[NUM_W:INTERVAL_BITS] != '0)
                    begin
                        interval_next = '1;
                    end
                    else
                    begin
                        interval_next = decel_sum[INTERVAL_BITS-1:0];
                    end
                end
            end
            default:
            begin
                // Hold until the result register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    cmp_out_next     = cvalid_pend_reg
                                     ? timer_reg + interval_reg[COMPARE_BITS-1:0]
                                     : '0;
                    cvalid_out_next  = cvalid_pend_reg;
                    phase_out_next   = phase_reg;
                    steps_out_next   = steps_reg;
                    reached_out_next = status_reg ? reached_pend_reg : done_reg;
                    halt_out_next    = halt_pend_reg;
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign compare_value = cmp_out_reg;
    assign compare_valid = cvalid_out_reg;
    assign phase_now     = phase_out_reg;
    assign steps_done    = steps_out_reg;
    assign reached_flag  = reached_out_reg;
    assign halt_timer    = halt_out_reg;

endmodule
